@@ sv/fg4_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// fg4_pkg
// Types, mode codes and codeword helpers for the T.6 two-dimensional coder.
// ---------------------------------------------------------------------------
package fg4_pkg;

  localparam int unsigned RunW  = 13;
  localparam int unsigned LineW = 13;

  localparam logic [1:0] KIND_PASS  = 2'd0;
  localparam logic [1:0] KIND_VERT  = 2'd1;
  localparam logic [1:0] KIND_HORIZ = 2'd2;

  localparam logic [1:0] PASS_BITS  = 2'd1;
  localparam logic [2:0] PASS_LEN   = 3'd4;
  localparam logic [1:0] HORIZ_BITS = 2'd1;
  localparam logic [2:0] HORIZ_LEN  = 3'd3;

  localparam logic [7:0] REG_LINE_WIDTH   = 8'd0;
  localparam logic [7:0] REG_BLACK_IS_ONE = 8'd1;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [2:0] voff;
    logic [1:0]        bits;
    logic [2:0]        len;
    logic [RunW-1:0]   run1;
    logic [RunW-1:0]   run2;
    logic              run1_white;
    logic              done;
  } res_t;

  function automatic res_t mk_pass();
    res_t r;
    r = '0;
    r.kind = KIND_PASS;
    r.bits = PASS_BITS;
    r.len  = PASS_LEN;
    return r;
  endfunction

  function automatic res_t mk_horiz(logic [RunW-1:0] r1, logic [RunW-1:0] r2,
                                    logic wh, logic dn);
    res_t r;
    r = '0;
    r.kind       = KIND_HORIZ;
    r.bits       = HORIZ_BITS;
    r.len        = HORIZ_LEN;
    r.run1       = r1;
    r.run2       = r2;
    r.run1_white = wh;
    r.done       = dn;
    return r;
  endfunction

  function automatic res_t mk_vert(logic signed [2:0] d, logic dn);
    res_t r;
    r = '0;
    r.kind = KIND_VERT;
    r.voff = d;
    r.done = dn;
    unique case (d)
      -3'sd3:  begin r.bits = 2'd2; r.len = 3'd7; end
      -3'sd2:  begin r.bits = 2'd2; r.len = 3'd6; end
      -3'sd1:  begin r.bits = 2'd2; r.len = 3'd3; end
      3'sd0:   begin r.bits = 2'd1; r.len = 3'd1; end
      3'sd1:   begin r.bits = 2'd3; r.len = 3'd3; end
      3'sd2:   begin r.bits = 2'd3; r.len = 3'd6; end
      3'sd3:   begin r.bits = 2'd3; r.len = 3'd7; end
      default: begin r.bits = 2'd0; r.len = 3'd0; end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/fax_g4_two_dimensional_line_coder_top.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// fax_g4_two_dimensional_line_coder_top
// T.6 mode coder: pixels in, pass / vertical / horizontal symbols out.
// ---------------------------------------------------------------------------
//  channel  | direction | word
//  s_axis   | in        | tdata[0] pixel_bit, tuser page_start
//  m_axis   | out       | tdata mode fields, tuser symbol_kind, tlast line_done
//  cfg      | in        | index 0 line_width, index 1 black_is_one
//
// A pixel is accepted, then decided. After each symbol, a page start or a
// line end the coder rescans the reference line from a0 to b2 at one read
// per cycle. A line end first copies the coding line into the reference memory.
// After reset and each page start the reference reads white via a fill mark.
// Up to two symbols queue at the output; a stalled output holds the coder.
// ---------------------------------------------------------------------------
module fax_g4_two_dimensional_line_coder_top #(
  parameter int unsigned MAX_LINE_WIDTH = 4096
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire logic [7:0]                  s_axis_tdata_i,  // [0] pixel_bit
  input  wire logic                        s_axis_tuser_i,  // [0] page_start
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  // [2:0] vertical_offset, [4:3] code_bits, [7:5] code_length,
  // [20:8] first_run, [33:21] second_run, [34] first_run_white
  output logic [39:0]                      m_axis_tdata_o,
  output logic [1:0]                       m_axis_tuser_o,  // [1:0] symbol_kind
  output logic                             m_axis_tlast_o,  // line_done
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [7:0]                  cfg_index_i,
  input  wire logic [fg4_pkg::LineW-1:0]   cfg_data_i
);
  import fg4_pkg::*;

  localparam int unsigned PW = $clog2(MAX_LINE_WIDTH + 1);
  localparam int unsigned AW = $clog2(MAX_LINE_WIDTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_PROC = 2'd2;
  localparam logic [1:0] ST_COPY = 2'd3;

  logic            ref_mem [MAX_LINE_WIDTH];
  logic            cur_mem [MAX_LINE_WIDTH];
  logic            ref_rd_q, cur_rd_q;
  logic            ref_re, ref_we, ref_wdata, cur_re, cur_we, cur_wdata;
  logic [AW-1:0]   ref_raddr, ref_waddr, cur_raddr, cur_waddr;

  logic [1:0]      state_q, state_d;
  logic [LineW-1:0] lw_q, lw_d;
  logic            blk_q, blk_d;
  logic [PW-1:0]   pos_q, pos_d, a0_q, a0_d, pa1_q, pa1_d, b1_q, b1_d, b2_q, b2_d;
  logic            a0_neg_q, a0_neg_d, col_q, col_d, pend_q, pend_d, bvalid_q, bvalid_d;
  logic [PW-1:0]   white_lo_q, white_lo_d;
  logic            hold_q, hold_d, pix_q, pix_d, ps_q, ps_d;
  logic [PW-1:0]   iss_q, iss_d, ridx_q, ridx_d;
  logic            rvld_q, rvld_d, first_q, first_d, phase_q, phase_d, prev_q, prev_d;
  logic [PW-1:0]   cp_q, cp_d;
  logic [AW-1:0]   cidx_q, cidx_d;
  logic            cvld_q, cvld_d;
  res_t            fifo_q [2];
  res_t            fifo_d [2];
  logic [1:0]      cnt_q, cnt_d;
  logic            head_q, head_d;

  logic [PW-1:0]   w, rs, rs2, na0, npa1, b1e, de;
  logic            na0neg, ncol, npend, changed, white, inrange, line_end, dbit;
  logic signed [PW:0] delta;
  res_t            s1, s2;
  logic            s1_v;
  logic            s_acc, m_acc, cfg_acc;

  always_comb begin
    if (lw_q == '0) begin
      w = PW'(1);
    end else if (32'(lw_q) > MAX_LINE_WIDTH) begin
      w = PW'(MAX_LINE_WIDTH);
    end else begin
      w = PW'(lw_q);
    end
  end

  assign cfg_ready_o     = (state_q == ST_IDLE);
  assign s_axis_tready_o = (state_q == ST_IDLE) && (bvalid_q || pend_q) && !cfg_valid_i;
  assign s_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_acc   = m_axis_tvalid_o && m_axis_tready_i;

  assign m_axis_tdata_o = {5'd0, fifo_q[head_q].run1_white, fifo_q[head_q].run2,
                           fifo_q[head_q].run1, fifo_q[head_q].len,
                           fifo_q[head_q].bits, fifo_q[head_q].voff};
  assign m_axis_tuser_o = fifo_q[head_q].kind;
  assign m_axis_tlast_o = fifo_q[head_q].done;

  // symbol decision for the held pixel
  always_comb begin
    white   = pix_q ^ blk_q;
    rs      = a0_neg_q ? '0 : a0_q;
    delta   = $signed({1'b0, pos_q}) - $signed({1'b0, b1_q});
    inrange = (delta >= -3) && (delta <= 3);
    na0 = a0_q; na0neg = a0_neg_q; ncol = col_q; npend = pend_q; npa1 = pa1_q;
    changed = 1'b0;
    s1_v = 1'b0;
    s1 = mk_pass();
    if (pend_q) begin
      if (white != col_q) begin
        s1 = mk_horiz(RunW'(pa1_q - rs), RunW'(pos_q - pa1_q), col_q, 1'b0);
        s1_v = 1'b1; na0 = pos_q; na0neg = 1'b0; npend = 1'b0; changed = 1'b1;
      end
    end else if (white == col_q) begin
      if (pos_q == b2_q) begin
        s1_v = 1'b1; na0 = pos_q; na0neg = 1'b0; changed = 1'b1;
      end
    end else if (inrange) begin
      s1 = mk_vert(3'(delta), 1'b0);
      s1_v = 1'b1; na0 = pos_q; na0neg = 1'b0; ncol = ~col_q; changed = 1'b1;
    end else begin
      npend = 1'b1; npa1 = pos_q;
    end
    line_end = (pos_q + PW'(1)) == w;
    rs2 = na0neg ? '0 : na0;
    b1e = changed ? w : b1_q;
    de  = w - b1e;
    if (npend) begin
      s2 = mk_horiz(RunW'(npa1 - rs2), RunW'(w - npa1), ncol, 1'b1);
    end else if (de <= PW'(3)) begin
      s2 = mk_vert(3'(de), 1'b1);
    end else begin
      s2 = mk_horiz(RunW'(w - rs2), '0, ncol, 1'b1);
    end
  end

  always_comb begin
    state_d = state_q; lw_d = lw_q; blk_d = blk_q;
    pos_d = pos_q; a0_d = a0_q; a0_neg_d = a0_neg_q; col_d = col_q;
    pa1_d = pa1_q; pend_d = pend_q; b1_d = b1_q; b2_d = b2_q; bvalid_d = bvalid_q;
    white_lo_d = white_lo_q; hold_d = hold_q; pix_d = pix_q; ps_d = ps_q;
    iss_d = iss_q; ridx_d = ridx_q; rvld_d = 1'b0; first_d = first_q;
    phase_d = phase_q; prev_d = prev_q; cp_d = cp_q; cidx_d = cidx_q; cvld_d = 1'b0;
    fifo_d = fifo_q; cnt_d = cnt_q; head_d = head_q;
    ref_re = 1'b0; ref_raddr = iss_q[AW-1:0];
    ref_we = 1'b0; ref_waddr = cidx_q; ref_wdata = cur_rd_q;
    cur_re = 1'b0; cur_raddr = cp_q[AW-1:0];
    cur_we = 1'b0; cur_waddr = pos_q[AW-1:0]; cur_wdata = white;
    dbit = (ridx_q >= white_lo_q) ? 1'b1 : ref_rd_q;

    if (m_acc) begin
      head_d = ~head_q;
      cnt_d  = cnt_q - 2'd1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_acc) begin
          if (cfg_index_i == REG_LINE_WIDTH) begin
            lw_d = cfg_data_i;
            pos_d = '0; a0_d = '0; a0_neg_d = 1'b1; col_d = 1'b1;
            pa1_d = '0; pend_d = 1'b0; bvalid_d = 1'b0;
          end else if (cfg_index_i == REG_BLACK_IS_ONE) begin
            blk_d = cfg_data_i[0];
          end
        end else if (!bvalid_q && !pend_q) begin
          state_d = ST_SCAN;
          iss_d   = a0_neg_q ? '0 : a0_q;
          first_d = !a0_neg_q;
          phase_d = 1'b0;
          prev_d  = 1'b1;
        end else if (s_acc) begin
          pix_d = s_axis_tdata_i[0];
          ps_d  = s_axis_tuser_i;
          hold_d = 1'b1;
          state_d = ST_PROC;
        end
      end
      ST_SCAN: begin
        ref_re = iss_q < w;
        if (ref_re) begin
          iss_d  = iss_q + PW'(1);
          rvld_d = 1'b1;
          ridx_d = iss_q;
        end
        if (rvld_q) begin
          prev_d = dbit;
          if (first_q) begin
            first_d = 1'b0;
          end else if (!phase_q) begin
            if (dbit != col_q && prev_q == col_q) begin
              b1_d = ridx_q;
              phase_d = 1'b1;
            end
          end else if (dbit != prev_q) begin
            b2_d = ridx_q;
            bvalid_d = 1'b1;
          end
        end
        if (!rvld_q && iss_q == w) begin
          if (!phase_q) b1_d = w;
          b2_d = w;
          bvalid_d = 1'b1;
        end
        if (bvalid_d) begin
          rvld_d  = 1'b0;
          state_d = hold_q ? ST_PROC : ST_IDLE;
        end
      end
      ST_PROC: begin
        if (ps_q) begin
          pos_d = '0; a0_d = '0; a0_neg_d = 1'b1; col_d = 1'b1;
          pa1_d = '0; pend_d = 1'b0; bvalid_d = 1'b0;
          white_lo_d = '0; ps_d = 1'b0;
          state_d = ST_SCAN;
          iss_d = '0; first_d = 1'b0; phase_d = 1'b0; prev_d = 1'b1;
        end else if (cnt_q == 2'd0) begin
          cur_we = 1'b1;
          hold_d = 1'b0;
          head_d = 1'b0;
          if (s1_v) begin
            fifo_d[0] = s1;
            fifo_d[1] = s2;
            cnt_d = line_end ? 2'd2 : 2'd1;
          end else begin
            fifo_d[0] = s2;
            cnt_d = line_end ? 2'd1 : 2'd0;
          end
          a0_d = na0; a0_neg_d = na0neg; col_d = ncol; pend_d = npend; pa1_d = npa1;
          if (changed) bvalid_d = 1'b0;
          pos_d = pos_q + PW'(1);
          state_d = ST_IDLE;
          if (line_end) begin
            pos_d = '0; a0_d = '0; a0_neg_d = 1'b1; col_d = 1'b1;
            pa1_d = '0; pend_d = 1'b0; bvalid_d = 1'b0;
            if (w > white_lo_q) white_lo_d = w;
            cp_d = '0;
            state_d = ST_COPY;
          end
        end
      end
      ST_COPY: begin
        cur_re = cp_q < w;
        if (cur_re) begin
          cp_d   = cp_q + PW'(1);
          cvld_d = 1'b1;
          cidx_d = cp_q[AW-1:0];
        end
        if (cvld_q) ref_we = 1'b1;
        if (!cvld_q && cp_q == w) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ref_we) ref_mem[ref_waddr] <= ref_wdata;
    if (ref_re) ref_rd_q <= ref_mem[ref_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cur_we) cur_mem[cur_waddr] <= cur_wdata;
    if (cur_re) cur_rd_q <= cur_mem[cur_raddr];
  end

  always_ff @(posedge clk_i) begin
    fifo_q <= fifo_d;
    pix_q  <= pix_d;
    b1_q   <= b1_d;
    b2_q   <= b2_d;
    ridx_q <= ridx_d;
    cidx_q <= cidx_d;
    prev_q <= prev_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; lw_q <= LineW'(1728); blk_q <= 1'b0;
      pos_q <= '0; a0_q <= '0; a0_neg_q <= 1'b1; col_q <= 1'b1;
      pa1_q <= '0; pend_q <= 1'b0; bvalid_q <= 1'b0; white_lo_q <= '0;
      hold_q <= 1'b0; ps_q <= 1'b0; iss_q <= '0; rvld_q <= 1'b0;
      first_q <= 1'b0; phase_q <= 1'b0; cp_q <= '0; cvld_q <= 1'b0;
      cnt_q <= 2'd0; head_q <= 1'b0;
    end else begin
      state_q <= state_d; lw_q <= lw_d; blk_q <= blk_d;
      pos_q <= pos_d; a0_q <= a0_d; a0_neg_q <= a0_neg_d; col_q <= col_d;
      pa1_q <= pa1_d; pend_q <= pend_d; bvalid_q <= bvalid_d; white_lo_q <= white_lo_d;
      hold_q <= hold_d; ps_q <= ps_d; iss_q <= iss_d; rvld_q <= rvld_d;
      first_q <= first_d; phase_q <= phase_d; cp_q <= cp_d; cvld_q <= cvld_d;
      cnt_q <= cnt_d; head_q <= head_d;
    end
  end

`ifndef SYNTH
  a_acc_needs_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |-> (bvalid_q || pend_q)) else $error("pixel taken without reference positions");
  a_cfg_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_acc |-> !hold_q) else $error("config write with a pixel in flight");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("result queue overflow");
`endif

endmodule
`default_nettype wire

@@ dv/tb_fax_g4_two_dimensional_line_coder_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_fax_g4_two_dimensional_line_coder_top
// Self-checking bench for the T.6 mode coder: pixel words are streamed in
// under random idling and a long output stall. A local predictor tracks a0,
// b1/b2 and the reference line and works out each pass, vertical or
// horizontal symbol. Every output word is compared against it field by field.
// ---------------------------------------------------------------------------
module tb_fax_g4_two_dimensional_line_coder_top;
  import fg4_pkg::*;

  localparam int MaxW      = 4096;
  localparam int StallLen  = 400;
  localparam int IdleLimit = 100000;

  typedef struct packed {
    bit px;
    bit pg;
  } pixel_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [LineW-1:0] cfg_data_i = '0;

  fax_g4_two_dimensional_line_coder_top dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  bit          ref_line [MaxW];
  bit          cur_line [MaxW];
  int          pix_pos, a0_pos, pend_a1;
  bit          colour_white, pend_valid;
  int          width_reg = 1728;
  bit          black_one;
  int          vbits [7] = '{2, 2, 2, 1, 3, 3, 3};
  int          vlen [7]  = '{7, 6, 3, 1, 3, 6, 7};

  pixel_word_t pixel_q [$];
  res_t        symbol_q [$];
  int          errors, n_pass, n_vert, n_horiz, n_lines, n_pixels;
  int          send_pct, recv_pct, stall_req, idle_cycles;
  bit          s_acc;

  // generator state
  bit          gen_prev [MaxW];

  function automatic int eff_width();
    if (width_reg < 1) return 1;
    if (width_reg > MaxW) return MaxW;
    return width_reg;
  endfunction

  function automatic void restart_line();
    pix_pos = 0;
    a0_pos = -1;
    colour_white = 1'b1;
    pend_a1 = 0;
    pend_valid = 1'b0;
  endfunction

  function automatic int run_origin();
    return (a0_pos < 0) ? 0 : a0_pos;
  endfunction

  function automatic int find_b1(int w);
    int pos;
    bit left;
    pos = run_origin() + ((a0_pos >= 0) ? 1 : 0);
    for (; pos < w; pos++) begin
      left = (pos == 0) ? 1'b1 : ref_line[pos-1];
      if (ref_line[pos] != colour_white && left == colour_white) return pos;
    end
    return w;
  endfunction

  function automatic int find_b2(int b1, int w);
    if (b1 >= w) return w;
    for (int pos = b1 + 1; pos < w; pos++)
      if (ref_line[pos] != ref_line[pos-1]) return pos;
    return w;
  endfunction

  function automatic void push_horiz(int r1, int r2, bit wh, bit dn);
    res_t r;
    r = '0;
    r.kind = KIND_HORIZ;
    r.bits = HORIZ_BITS;
    r.len = HORIZ_LEN;
    r.run1 = r1[RunW-1:0];
    r.run2 = r2[RunW-1:0];
    r.run1_white = wh;
    r.done = dn;
    symbol_q.push_back(r);
  endfunction

  function automatic void push_vert(int d, bit dn);
    res_t r;
    r = '0;
    r.kind = KIND_VERT;
    r.voff = d[2:0];
    r.bits = vbits[d+3][1:0];
    r.len = vlen[d+3][2:0];
    r.done = dn;
    symbol_q.push_back(r);
  endfunction

  function automatic void code_pixel(bit raw, bit pg);
    int w, p, b1, b2, d;
    bit wh;
    res_t r;
    w = eff_width();
    wh = raw ^ black_one;
    if (pg) begin
      foreach (ref_line[i]) ref_line[i] = 1'b1;
      restart_line();
    end
    if (pix_pos >= w) restart_line();
    p = pix_pos;
    cur_line[p] = wh;
    if (pend_valid) begin
      if (wh != colour_white) begin
        push_horiz(pend_a1 - run_origin(), p - pend_a1, colour_white, 1'b0);
        a0_pos = p;
        pend_valid = 1'b0;
      end
    end else begin
      b1 = find_b1(w);
      b2 = find_b2(b1, w);
      if (wh == colour_white) begin
        if (p == b2) begin
          r = '0;
          r.kind = KIND_PASS;
          r.bits = PASS_BITS;
          r.len = PASS_LEN;
          symbol_q.push_back(r);
          a0_pos = p;
        end
      end else begin
        d = p - b1;
        if (d >= -3 && d <= 3) begin
          push_vert(d, 1'b0);
          a0_pos = p;
          colour_white ^= 1'b1;
        end else begin
          pend_a1 = p;
          pend_valid = 1'b1;
        end
      end
    end
    pix_pos = p + 1;
    if (pix_pos == w) begin
      if (pend_valid) begin
        push_horiz(pend_a1 - run_origin(), w - pend_a1, colour_white, 1'b1);
      end else begin
        b1 = find_b1(w);
        d = w - b1;
        if (d <= 3) push_vert(d, 1'b1);
        else push_horiz(w - run_origin(), 0, colour_white, 1'b1);
      end
      for (int i = 0; i < w; i++) ref_line[i] = cur_line[i];
      restart_line();
    end
  endfunction

  // driver: pixel words
  always @(negedge clk_i) begin
    pixel_word_t it;
    if (!s_axis_tvalid_i || s_acc) begin
      if (pixel_q.size() > 0 && $urandom_range(99) >= send_pct) begin
        it = pixel_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= {7'd0, it.px};
        s_axis_tuser_i  <= it.pg;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver with its own long stall
  always @(negedge clk_i) begin
    int hold, seen;
    if (stall_req != seen) begin
      seen = stall_req;
      hold = StallLen;
    end
    if (hold > 0) begin
      hold--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_pct);
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    res_t e;
    bit any;
    any = 1'b0;
    s_acc <= s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      any = 1'b1;
      if (cfg_index_i == REG_LINE_WIDTH) begin
        width_reg = int'(cfg_data_i);
        restart_line();
      end else if (cfg_index_i == REG_BLACK_IS_ONE) begin
        black_one = cfg_data_i[0];
      end
    end
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      any = 1'b1;
      n_pixels++;
      code_pixel(s_axis_tdata_i[0], s_axis_tuser_i);
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      any = 1'b1;
      if (symbol_q.size() == 0) begin
        $error("unexpected symbol kind %0d", m_axis_tuser_o);
        errors++;
      end else begin
        e = symbol_q.pop_front();
        case (e.kind)
          KIND_PASS: n_pass++;
          KIND_VERT: n_vert++;
          default:   n_horiz++;
        endcase
        if (e.done) n_lines++;
        if (m_axis_tuser_o !== e.kind) begin
          $error("symbol_kind exp %0d got %0d", e.kind, m_axis_tuser_o); errors++;
        end
        if (m_axis_tdata_o[2:0] !== e.voff) begin
          $error("vertical_offset exp %0d got %0d", e.voff,
                 $signed(m_axis_tdata_o[2:0])); errors++;
        end
        if (m_axis_tdata_o[4:3] !== e.bits) begin
          $error("code_bits exp %0d got %0d", e.bits, m_axis_tdata_o[4:3]); errors++;
        end
        if (m_axis_tdata_o[7:5] !== e.len) begin
          $error("code_length exp %0d got %0d", e.len, m_axis_tdata_o[7:5]); errors++;
        end
        if (m_axis_tdata_o[20:8] !== e.run1) begin
          $error("first_run exp %0d got %0d", e.run1, m_axis_tdata_o[20:8]); errors++;
        end
        if (m_axis_tdata_o[33:21] !== e.run2) begin
          $error("second_run exp %0d got %0d", e.run2, m_axis_tdata_o[33:21]); errors++;
        end
        if (m_axis_tdata_o[34] !== e.run1_white) begin
          $error("first_run_white exp %0d got %0d", e.run1_white, m_axis_tdata_o[34]);
          errors++;
        end
        if (m_axis_tlast_o !== e.done) begin
          $error("line_done exp %0d got %0d", e.done, m_axis_tlast_o); errors++;
        end
      end
    end
    idle_cycles = any ? 0 : idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("FAIL fax_g4_two_dimensional_line_coder_top");
      $finish;
    end
  end

  task automatic write_reg(logic [7:0] idx, int val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val[LineW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    int lat;
    wait (pixel_q.size() == 0);
    @(negedge clk_i);
    while (s_axis_tvalid_i || symbol_q.size() > 0) @(negedge clk_i);
    lat = 3 * eff_width() + 64;
    repeat (lat) @(posedge clk_i);
  endtask

  // kind 0: shifted copy of previous line, 1: random runs, 2: noise
  task automatic queue_line(int w, int kind, int pg_pct);
    bit line [MaxW];
    bit c;
    int shift, run;
    shift = $urandom_range(8) - 4;
    c = $urandom_range(1);
    run = 0;
    for (int i = 0; i < w; i++) begin
      case (kind)
        0: begin
          line[i] = (i + shift >= 0 && i + shift < w) ? gen_prev[i+shift] : 1'b0;
          if ($urandom_range(99) < 3) shift = $urandom_range(8) - 4;
        end
        1: begin
          if (run == 0) begin
            c = ~c;
            run = $urandom_range(($urandom_range(3) == 0) ? 20 : 6, 1);
          end
          run--;
          line[i] = c;
        end
        default: line[i] = $urandom_range(1);
      endcase
      pixel_q.push_back('{px: line[i],
                          pg: ($urandom_range(99) < pg_pct)});
    end
    for (int i = 0; i < w; i++) gen_prev[i] = line[i];
  endtask

  task automatic queue_fixed(int w, bit val);
    for (int i = 0; i < w; i++) begin
      pixel_q.push_back('{px: val, pg: 1'b0});
      gen_prev[i] = val;
    end
  endtask

  initial begin
    int w;
    send_pct = 32;
    recv_pct = 71;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: narrow lines, solid colours, page restart mid-line
    write_reg(REG_LINE_WIDTH, 1);
    write_reg(REG_BLACK_IS_ONE, 0);
    pixel_q.push_back('{px: 1'b0, pg: 1'b1});
    pixel_q.push_back('{px: 1'b1, pg: 1'b0});
    pixel_q.push_back('{px: 1'b0, pg: 1'b0});
    drain();
    write_reg(REG_LINE_WIDTH, 6);
    queue_fixed(6, 1'b1);
    queue_fixed(6, 1'b1);
    queue_fixed(6, 1'b0);
    pixel_q.push_back('{px: 1'b1, pg: 1'b0});
    pixel_q.push_back('{px: 1'b1, pg: 1'b1});
    drain();
    write_reg(REG_LINE_WIDTH, 0);
    pixel_q.push_back('{px: 1'b1, pg: 1'b0});
    drain();
    // out-of-range width, line abandoned by a width write
    write_reg(REG_LINE_WIDTH, 8191);
    repeat (5) pixel_q.push_back('{px: 1'b1, pg: 1'b0});
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_pct = 71;
        recv_pct = 32;
      end
      if (ph == 8) begin
        send_pct = 0;
        recv_pct = 0;
      end
      w = (ph % 4 == 3) ? $urandom_range(64, 33) : $urandom_range(24, 4);
      write_reg(REG_LINE_WIDTH, w);
      write_reg(REG_BLACK_IS_ONE, ph[0]);
      pixel_q.push_back('{px: 1'b0, pg: 1'b1});
      for (int i = 1; i < w; i++) pixel_q.push_back('{px: 1'b0, pg: 1'b0});
      for (int i = 0; i < w; i++) gen_prev[i] = 1'b0;
      while (pixel_q.size() < 24) queue_line(w, ($urandom_range(9) < 7) ? 0 :
                                             $urandom_range(2, 1), 1);
      if (ph == 5) stall_req++;
      drain();
    end

    // widest line, start of a page with a few runs
    write_reg(REG_LINE_WIDTH, MaxW);
    write_reg(REG_BLACK_IS_ONE, 1);
    for (int i = 0; i < 24; i++)
      pixel_q.push_back('{px: (i % 8 > 5), pg: (i == 0)});
    drain();

    $display("covered %0d pixels over %0d coded lines", n_pixels, n_lines);
    $display("symbols: %0d pass, %0d vertical, %0d horizontal", n_pass, n_vert, n_horiz);
    if (errors == 0 && symbol_q.size() == 0) begin
      $display("PASS fax_g4_two_dimensional_line_coder_top");
    end else begin
      if (symbol_q.size() > 0) $error("%0d symbols never arrived", symbol_q.size());
      $display("FAIL fax_g4_two_dimensional_line_coder_top");
    end
    $finish;
  end

  initial begin
    foreach (ref_line[i]) ref_line[i] = 1'b1;
    restart_line();
  end

endmodule
